// File: rtl/sspb_pkg.sv
`timescale 1ns / 1ps
package sspb_pkg;

	localparam int FREQ_W    = 36;
	localparam int RATE_W    = 32;
	localparam int BINS_W    = 13;
	localparam int FFT_W     = 11;
	localparam int IDX_W     = 10;
	localparam int LVL_W     = 16;
	localparam int RIDX_W    = 12;
	localparam int OUT_W     = 8;
	localparam int CFG_IDX_W = 3;
	localparam int DIV_W     = FFT_W + RATE_W;

	localparam logic [OUT_W-1:0] NO_DATA = 8'h80;
	localparam logic signed [LVL_W-1:0] LEVEL_CLAMP = 16'sd32512;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_FOLD  = 2'd1,
		CMD_READ  = 2'd2,
		CMD_COUNT = 2'd3
	} cmd_t;

	localparam logic [CFG_IDX_W-1:0] REG_START_FREQ = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RATE       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_SPAN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DC_GUARD   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BINS       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FFT_SIZE   = 3'd6;

	typedef struct packed {
		logic [FREQ_W-1:0] start_frequency;
		logic [RATE_W-1:0] output_bin_width;
		logic [RATE_W-1:0] sample_rate;
		logic [RATE_W-1:0] trusted_half_span;
		logic [RATE_W-1:0] dc_guard;
		logic [BINS_W-1:0] bins_in_use;
		logic [FFT_W-1:0]  fft_size;
	} cfg_t;

	typedef struct packed {
		cmd_t                     cmd;
		logic [FREQ_W-1:0]        tune_center;
		logic [IDX_W-1:0]         fft_index;
		logic signed [OUT_W-1:0]  level;
		logic [RIDX_W-1:0]        read_index;
	} item_t;

	typedef struct packed {
		logic pop;
		logic init;
	} back_stat_t;

	function automatic logic signed [OUT_W-1:0] quantise(input logic signed [LVL_W-1:0] v);
		logic signed [LVL_W-1:0] c;
		logic [LVL_W-1:0] mag;
		logic [OUT_W-1:0] q;
		c = v;
		if (c > LEVEL_CLAMP) c = LEVEL_CLAMP;
		if (c < -LEVEL_CLAMP) c = -LEVEL_CLAMP;
		mag = c[LVL_W-1] ? LVL_W'(-c) : LVL_W'(c);
		q = OUT_W'((mag + 16'd128) >> 8);
		return c[LVL_W-1] ? $signed(-q) : $signed(q);
	endfunction

endpackage

// File: rtl/sspb_div.sv
`timescale 1ns / 1ps
module sspb_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [sspb_pkg::DIV_W-1:0]   dividend,
	input  logic [sspb_pkg::RATE_W-1:0]  divisor,
	output logic                         busy,
	output logic                         done,
	output logic [sspb_pkg::DIV_W-1:0]   quotient
);
	import sspb_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [RATE_W-1:0] rem_q;
	logic [RATE_W-1:0] dsr_q;
	logic [DIV_W-1:0]  quo_q;
	logic [RATE_W:0]   rem_sh;
	logic              fits;

	assign rem_sh = {rem_q, quo_q[DIV_W-1]};
	assign fits   = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? RATE_W'(rem_sh - {1'b0, dsr_q}) : RATE_W'(rem_sh);
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

`ifndef SYNTHESIS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("Divider restarted while busy.");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("Divider done without a division.");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("Divider done held for two cycles.");
`endif
endmodule

// File: rtl/sspb_front.sv
`timescale 1ns / 1ps
module sspb_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         cmd,
	input  logic [sspb_pkg::FREQ_W-1:0]        tune_center,
	input  logic [sspb_pkg::IDX_W-1:0]         fft_index,
	input  logic signed [sspb_pkg::LVL_W-1:0]  level_db,
	input  logic [sspb_pkg::RIDX_W-1:0]        read_index,
	input  sspb_pkg::back_stat_t               back_stat,
	output logic                               item_valid,
	output sspb_pkg::item_t                    item
);
	import sspb_pkg::*;

	item_t      fifo_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] fill_q;
	logic       push;
	item_t      new_item;

	assign busy = (fill_q == 2'd2) || back_stat.init;
	assign push = start && !busy;

	always_comb begin
		new_item.cmd         = cmd_t'(cmd);
		new_item.tune_center = tune_center;
		new_item.fft_index   = fft_index;
		new_item.level       = quantise(level_db);
		new_item.read_index  = read_index;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fill_q <= '0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (back_stat.pop) rptr_q <= ~rptr_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, back_stat.pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wptr_q] <= new_item;
	end

	assign item_valid = fill_q != 2'd0;
	assign item       = fifo_q[rptr_q];

`ifndef SYNTHESIS
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.pop |-> item_valid) else $error("Queue popped while empty.");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != 2'd3) else $error("Queue overfilled.");
	a_no_push_init: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.init |-> !push) else $error("Transaction taken during init.");
`endif
endmodule

// File: rtl/sspb_back.sv
`timescale 1ns / 1ps
module sspb_back #(
	parameter int MAX_BINS = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sspb_pkg::cfg_t                    cfg,
	input  logic                              item_valid,
	input  sspb_pkg::item_t                   item,
	output sspb_pkg::back_stat_t              back_stat,
	output logic                              done,
	output logic                              bin_valid,
	output logic [sspb_pkg::RIDX_W-1:0]       bin_number,
	output logic signed [sspb_pkg::OUT_W-1:0] level_out,
	output logic [sspb_pkg::BINS_W-1:0]       empty_count
);
	import sspb_pkg::*;

	localparam int AW = $clog2(MAX_BINS);
	localparam int CW = AW + 1;

	typedef enum logic [3:0] {
		ST_INIT, ST_IDLE, ST_PREP, ST_DS1, ST_DIV1, ST_CHK, ST_CHK2,
		ST_DS2, ST_DIV2, ST_BIN, ST_RMW, ST_READ, ST_READ2, ST_CLR, ST_CNT
	} state_t;

	state_t            state_q;
	item_t             cur_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     acc_q;
	logic              rv_q;
	logic [DIV_W-1:0]  prod_q;
	logic              neg_q;
	logic [DIV_W-1:0]  above_q;
	logic [FREQ_W:0]   hz_q;
	logic [DIV_W-1:0]  rel_q;
	logic [AW-1:0]     bin_q;
	logic              done_q;
	logic              valid_q;
	logic [RIDX_W-1:0] number_q;
	logic [OUT_W-1:0]  level_q;
	logic [BINS_W-1:0] empty_q;

	logic [OUT_W-1:0]  mem [MAX_BINS];
	logic [OUT_W-1:0]  rdata_q;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [OUT_W-1:0]  mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;

	logic              div_start;
	logic [DIV_W-1:0]  div_dividend;
	logic [RATE_W-1:0] div_divisor;
	logic              div_busy;
	logic              div_done;
	logic [DIV_W-1:0]  div_quot;

	logic [CW-1:0]     lim;
	logic [FFT_W-1:0]  half;
	logic              idx_neg;
	logic [FFT_W-1:0]  offs;
	logic              prep_fail;
	logic              chk_fail;
	logic              bin_fail;
	logic              replace;

	sspb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign lim = (32'(cfg.bins_in_use) < MAX_BINS) ? CW'(cfg.bins_in_use) : CW'(MAX_BINS);
	assign half      = cfg.fft_size >> 1;
	assign idx_neg   = {1'b0, cur_q.fft_index} < half;
	assign offs      = idx_neg ? half - {1'b0, cur_q.fft_index}
	                           : {1'b0, cur_q.fft_index} - half;
	assign prep_fail = (cfg.fft_size == '0) || ({1'b0, cur_q.fft_index} >= cfg.fft_size)
	                   || (cfg.output_bin_width == '0);
	assign chk_fail  = (neg_q && above_q != '0) || (above_q < DIV_W'(cfg.dc_guard))
	                   || (above_q >= DIV_W'(cfg.trusted_half_span));
	assign bin_fail  = (div_quot >= DIV_W'(cfg.bins_in_use)) || (div_quot >= DIV_W'(MAX_BINS));
	assign replace   = (rdata_q == NO_DATA) || ($signed(cur_q.level) > $signed(rdata_q));

	always_comb begin
		div_start    = 1'b0;
		div_dividend = prod_q;
		div_divisor  = RATE_W'(cfg.fft_size);
		mem_we       = 1'b0;
		mem_waddr    = AW'(cnt_q);
		mem_wdata    = NO_DATA;
		mem_re       = 1'b0;
		mem_raddr    = AW'(cnt_q);
		unique case (state_q)
			ST_INIT: mem_we = 1'b1;
			ST_DS1: div_start = 1'b1;
			ST_DS2: begin
				div_start    = 1'b1;
				div_dividend = rel_q;
				div_divisor  = cfg.output_bin_width;
			end
			ST_BIN: begin
				mem_re    = 1'b1;
				mem_raddr = AW'(div_quot);
			end
			ST_RMW: begin
				mem_we    = replace;
				mem_waddr = bin_q;
				mem_wdata = cur_q.level;
			end
			ST_READ: begin
				mem_re    = 1'b1;
				mem_raddr = AW'(cur_q.read_index);
			end
			ST_CLR: mem_we = cnt_q < lim;
			ST_CNT: mem_re = cnt_q < lim;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			cnt_q    <= '0;
			acc_q    <= '0;
			rv_q     <= 1'b0;
			done_q   <= 1'b0;
			valid_q  <= 1'b0;
			number_q <= '0;
			level_q  <= '0;
			empty_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(MAX_BINS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (item_valid) begin
						cnt_q <= '0;
						acc_q <= '0;
						rv_q  <= 1'b0;
						unique case (item.cmd)
							CMD_FOLD:  state_q <= ST_PREP;
							CMD_READ:  state_q <= ST_READ;
							CMD_CLEAR: state_q <= ST_CLR;
							CMD_COUNT: state_q <= ST_CNT;
							default:   state_q <= ST_IDLE;
						endcase
					end
				end
				ST_PREP: begin
					neg_q  <= idx_neg;
					prod_q <= DIV_W'(offs) * DIV_W'(cfg.sample_rate);
					if (prep_fail) begin
						done_q   <= 1'b1;
						valid_q  <= 1'b0;
						number_q <= '0;
						level_q  <= cur_q.level;
						empty_q  <= '0;
						state_q  <= ST_IDLE;
					end else begin
						state_q <= ST_DS1;
					end
				end
				ST_DS1: state_q <= ST_DIV1;
				ST_DIV1: begin
					if (div_done) begin
						above_q <= div_quot;
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					hz_q <= {1'b0, cur_q.tune_center} + (FREQ_W+1)'(above_q[RATE_W-1:0]);
					if (chk_fail) begin
						done_q   <= 1'b1;
						valid_q  <= 1'b0;
						number_q <= '0;
						level_q  <= cur_q.level;
						empty_q  <= '0;
						state_q  <= ST_IDLE;
					end else begin
						state_q <= ST_CHK2;
					end
				end
				ST_CHK2: begin
					rel_q <= DIV_W'(hz_q - {1'b0, cfg.start_frequency});
					if (hz_q < {1'b0, cfg.start_frequency}) begin
						done_q   <= 1'b1;
						valid_q  <= 1'b0;
						number_q <= '0;
						level_q  <= cur_q.level;
						empty_q  <= '0;
						state_q  <= ST_IDLE;
					end else begin
						state_q <= ST_DS2;
					end
				end
				ST_DS2: state_q <= ST_DIV2;
				ST_DIV2: begin
					if (div_done) state_q <= ST_BIN;
				end
				ST_BIN: begin
					bin_q <= AW'(div_quot);
					if (bin_fail) begin
						done_q   <= 1'b1;
						valid_q  <= 1'b0;
						number_q <= '0;
						level_q  <= cur_q.level;
						empty_q  <= '0;
						state_q  <= ST_IDLE;
					end else begin
						state_q <= ST_RMW;
					end
				end
				ST_RMW: begin
					done_q   <= 1'b1;
					valid_q  <= 1'b1;
					number_q <= RIDX_W'(bin_q);
					level_q  <= cur_q.level;
					empty_q  <= '0;
					state_q  <= ST_IDLE;
				end
				ST_READ: state_q <= ST_READ2;
				ST_READ2: begin
					done_q   <= 1'b1;
					valid_q  <= 1'b0;
					number_q <= cur_q.read_index;
					level_q  <= (32'(cur_q.read_index) < MAX_BINS) ? rdata_q : NO_DATA;
					empty_q  <= '0;
					state_q  <= ST_IDLE;
				end
				ST_CLR: begin
					if (cnt_q < lim) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						done_q   <= 1'b1;
						valid_q  <= 1'b0;
						number_q <= '0;
						level_q  <= '0;
						empty_q  <= '0;
						state_q  <= ST_IDLE;
					end
				end
				ST_CNT: begin
					rv_q <= cnt_q < lim;
					if (cnt_q < lim) cnt_q <= cnt_q + 1'b1;
					if (rv_q && rdata_q == NO_DATA) acc_q <= acc_q + 1'b1;
					if (!(cnt_q < lim) && !rv_q) begin
						done_q   <= 1'b1;
						valid_q  <= 1'b0;
						number_q <= '0;
						level_q  <= '0;
						empty_q  <= BINS_W'(acc_q);
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_valid) cur_q <= item;
	end

	assign back_stat.pop  = (state_q == ST_IDLE) && item_valid;
	assign back_stat.init = state_q == ST_INIT;
	assign done           = done_q;
	assign bin_valid      = valid_q;
	assign bin_number     = number_q;
	assign level_out      = level_q;
	assign empty_count    = empty_q;

`ifndef SYNTHESIS
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("Two results on back to back cycles.");
	a_no_done_init: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INIT) |-> !done_q) else $error("Result during init pass.");
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy) else $error("Division issued while divider busy.");
	a_one_port_each: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (state_q == ST_RMW || state_q == ST_CLR))
		else $error("Unexpected store access pair.");
`endif
endmodule

// File: rtl/spectrum_sweep_peak_hold_binner.sv
`timescale 1ns / 1ps
// Max-hold spectrum binner. A transaction is taken when start is high and busy is low; each one
// gives exactly one result, shown for one cycle with done high, which the receiver must take
// then. After reset the block sweeps the whole store to no-data, one entry per cycle, with busy
// high. A fold runs two 43-step passes of the shared bit-serial divider (bin offset, then output
// bin) plus a read-modify-write; a fold that fails an early check ends sooner. A read looks up
// one store entry; a clear or a count walks min(bins_in_use, MAX_BINS) store entries, one entry
// per cycle. Two transactions can wait in the input queue. The user must write configuration
// only while no transaction is outstanding; the block itself does not enforce it.
module spectrum_sweep_peak_hold_binner #(
	parameter int MAX_BINS = 4096
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         cmd,
	input  logic [sspb_pkg::FREQ_W-1:0]        tune_center,
	input  logic [sspb_pkg::IDX_W-1:0]         fft_index,
	input  logic signed [sspb_pkg::LVL_W-1:0]  level_db,
	input  logic [sspb_pkg::RIDX_W-1:0]        read_index,
	input  logic                               wr_en,
	input  logic [sspb_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [sspb_pkg::FREQ_W-1:0]        wr_data,
	output logic                               done,
	output logic                               bin_valid,
	output logic [sspb_pkg::RIDX_W-1:0]        bin_number,
	output logic signed [sspb_pkg::OUT_W-1:0]  level_out,
	output logic [sspb_pkg::BINS_W-1:0]        empty_count
);
	import sspb_pkg::*;

	cfg_t       cfg_q;
	item_t      item;
	logic       item_valid;
	back_stat_t back_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_frequency   <= '0;
			cfg_q.output_bin_width  <= RATE_W'(1);
			cfg_q.sample_rate       <= RATE_W'(1);
			cfg_q.trusted_half_span <= '0;
			cfg_q.dc_guard          <= '0;
			cfg_q.bins_in_use       <= BINS_W'(1);
			cfg_q.fft_size          <= FFT_W'(1024);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_START_FREQ: cfg_q.start_frequency   <= wr_data;
				REG_BIN_WIDTH:  cfg_q.output_bin_width  <= wr_data[RATE_W-1:0];
				REG_RATE:       cfg_q.sample_rate       <= wr_data[RATE_W-1:0];
				REG_HALF_SPAN:  cfg_q.trusted_half_span <= wr_data[RATE_W-1:0];
				REG_DC_GUARD:   cfg_q.dc_guard          <= wr_data[RATE_W-1:0];
				REG_BINS:       cfg_q.bins_in_use       <= wr_data[BINS_W-1:0];
				REG_FFT_SIZE:   cfg_q.fft_size          <= wr_data[FFT_W-1:0];
				default: ;
			endcase
		end
	end

	sspb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.tune_center (tune_center),
		.fft_index   (fft_index),
		.level_db    (level_db),
		.read_index  (read_index),
		.back_stat   (back_stat),
		.item_valid  (item_valid),
		.item        (item)
	);

	sspb_back #(
		.MAX_BINS (MAX_BINS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.item_valid  (item_valid),
		.item        (item),
		.back_stat   (back_stat),
		.done        (done),
		.bin_valid   (bin_valid),
		.bin_number  (bin_number),
		.level_out   (level_out),
		.empty_count (empty_count)
	);
endmodule

// File: sim/sspb_checker.sv
`timescale 1ns / 1ps
module sspb_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               busy,
	input  logic [1:0]                         cmd,
	input  logic [sspb_pkg::FREQ_W-1:0]        tune_center,
	input  logic [sspb_pkg::IDX_W-1:0]         fft_index,
	input  logic signed [sspb_pkg::LVL_W-1:0]  level_db,
	input  logic [sspb_pkg::RIDX_W-1:0]        read_index,
	input  logic                               wr_en,
	input  logic [sspb_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [sspb_pkg::FREQ_W-1:0]        wr_data,
	input  logic                               done,
	input  logic                               bin_valid,
	input  logic [sspb_pkg::RIDX_W-1:0]        bin_number,
	input  logic signed [sspb_pkg::OUT_W-1:0]  level_out,
	input  logic [sspb_pkg::BINS_W-1:0]        empty_count,
	output int                                 errors,
	output int                                 pending,
	output int                                 seen_hits
);
	import sspb_pkg::*;

	localparam int STORE_DEPTH = 4096;

	typedef struct packed {
		logic                     valid;
		logic [RIDX_W-1:0]        number;
		logic signed [OUT_W-1:0]  level;
		logic [BINS_W-1:0]        empty;
	} bin_result_t;

	logic [63:0] base_hz, width_hz, rate_hz, span_lim_hz, guard_hz, bins_used, fft_points;
	logic [OUT_W-1:0] peaks [STORE_DEPTH];
	bin_result_t expected_results[$];

	assign pending = expected_results.size();

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic logic signed [OUT_W-1:0] round_level(input logic signed [LVL_W-1:0] raw);
		int v;
		int m;
		v = raw;
		if (v > 32512) v = 32512;
		if (v < -32512) v = -32512;
		m = (v < 0 ? -v : v);
		m = (m + 128) >> 8;
		return OUT_W'(v < 0 ? -m : m);
	endfunction

	function automatic logic locate_bin(input logic [63:0] center, input logic [63:0] idx,
			output logic [63:0] bin);
		logic [63:0] half, steps, above, hz, slot;
		logic below;
		bin = 0;
		if (fft_points == 0 || idx >= fft_points || width_hz == 0) return 0;
		half = fft_points / 2;
		below = idx < half;
		steps = below ? half - idx : idx - half;
		above = (steps * rate_hz) / fft_points;
		if (below && above != 0) return 0;
		if (above < guard_hz || above >= span_lim_hz) return 0;
		hz = center + above;
		if (hz < base_hz) return 0;
		slot = (hz - base_hz) / width_hz;
		if (slot >= bins_used || slot >= STORE_DEPTH) return 0;
		bin = slot;
		return 1;
	endfunction

	function automatic bin_result_t predict_result(input cmd_t op, input logic [63:0] center,
			input logic [63:0] idx, input logic signed [LVL_W-1:0] raw, input logic [63:0] rd);
		bin_result_t r;
		logic [63:0] lim, bin;
		logic signed [OUT_W-1:0] q;
		r = '0;
		lim = bins_used < STORE_DEPTH ? bins_used : STORE_DEPTH;
		case (op)
			CMD_CLEAR: begin
				for (int i = 0; i < lim; i++) peaks[i] = NO_DATA;
			end
			CMD_FOLD: begin
				q = round_level(raw);
				r.level = q;
				if (locate_bin(center, idx, bin)) begin
					if (peaks[bin] == NO_DATA || q > $signed(peaks[bin])) peaks[bin] = q;
					r.valid = 1;
					r.number = bin[RIDX_W-1:0];
				end
			end
			CMD_READ: begin
				r.number = rd[RIDX_W-1:0];
				r.level = peaks[rd];
			end
			default: begin
				for (int i = 0; i < lim; i++) if (peaks[i] == NO_DATA) r.empty++;
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bin_result_t want;
		if (!arst_n) begin
			base_hz <= 0;
			width_hz <= 1;
			rate_hz <= 1;
			span_lim_hz <= 0;
			guard_hz <= 0;
			bins_used <= 1;
			fft_points <= 1024;
			for (int i = 0; i < STORE_DEPTH; i++) peaks[i] = NO_DATA;
			expected_results.delete();
			errors = 0;
			seen_hits = 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_START_FREQ: base_hz <= wr_data;
					REG_BIN_WIDTH:  width_hz <= wr_data[31:0];
					REG_RATE:       rate_hz <= wr_data[31:0];
					REG_HALF_SPAN:  span_lim_hz <= wr_data[31:0];
					REG_DC_GUARD:   guard_hz <= wr_data[31:0];
					REG_BINS:       bins_used <= wr_data[BINS_W-1:0];
					REG_FFT_SIZE:   fft_points <= wr_data[FFT_W-1:0];
					default: ;
				endcase
			end
			if (done) begin
				if (expected_results.size() == 0) begin
					report("unexpected result", 0, 0);
				end else begin
					want = expected_results.pop_front();
					if (bin_valid) seen_hits++;
					if (bin_valid !== want.valid) report("bin_valid", bin_valid, want.valid);
					if (bin_number !== want.number) report("bin_number", bin_number, want.number);
					if (level_out !== want.level) report("level_out", level_out, want.level);
					if (empty_count !== want.empty)
						report("empty_count", empty_count, want.empty);
				end
			end
			if (start && !busy)
				expected_results.push_back(predict_result(cmd_t'(cmd), tune_center,
					fft_index, level_db, read_index));
		end
	end
endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import sspb_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [1:0] cmd = CMD_CLEAR;
	logic [FREQ_W-1:0] tune_center = 0;
	logic [IDX_W-1:0] fft_index = 0;
	logic signed [LVL_W-1:0] level_db = 0;
	logic [RIDX_W-1:0] read_index = 0;
	logic wr_en = 0;
	logic [CFG_IDX_W-1:0] wr_index = REG_START_FREQ;
	logic [FREQ_W-1:0] wr_data = 0;
	logic done, bin_valid;
	logic [RIDX_W-1:0] bin_number;
	logic signed [OUT_W-1:0] level_out;
	logic [BINS_W-1:0] empty_count;
	int errors, pending, seen_hits;
	int sent_items;
	int burst_left;
	logic [63:0] cur_start, cur_width, cur_rate;
	logic [63:0] cur_fft;

	always #2 clk = ~clk;

	spectrum_sweep_peak_hold_binner dut (.*);

	sspb_checker checker_i (.*);

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
		@(negedge clk);
		wr_en <= 1;
		wr_index <= idx;
		wr_data <= value[FREQ_W-1:0];
		@(negedge clk);
		wr_en <= 0;
	endtask

	task automatic drain_block();
		if (burst_left != 0) begin
			start <= 0;
			burst_left = 0;
		end
		while (pending != 0 || busy) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic set_plan(input logic [63:0] s, input logic [63:0] w, input logic [63:0] r,
			input logic [63:0] hs, input logic [63:0] g, input logic [63:0] b,
			input logic [63:0] n);
		drain_block();
		write_reg(REG_START_FREQ, s);
		write_reg(REG_BIN_WIDTH, w);
		write_reg(REG_RATE, r);
		write_reg(REG_HALF_SPAN, hs);
		write_reg(REG_DC_GUARD, g);
		write_reg(REG_BINS, b);
		write_reg(REG_FFT_SIZE, n);
		cur_start = s;
		cur_width = w;
		cur_rate = r;
		cur_fft = n;
	endtask

	task automatic issue(input cmd_t op, input logic [63:0] center, input logic [63:0] idx,
			input logic [15:0] lvl, input logic [63:0] rd);
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		start <= 1;
		cmd <= op;
		tune_center <= center[FREQ_W-1:0];
		fft_index <= idx[IDX_W-1:0];
		level_db <= lvl;
		read_index <= rd[RIDX_W-1:0];
		while (busy) @(negedge clk);
		@(negedge clk);
		burst_left--;
		sent_items++;
		if (burst_left == 0) start <= 0;
	endtask

	task automatic random_fold();
		logic [63:0] center;
		logic [15:0] lvl;
		center = cur_start + $urandom_range(0, 64) * cur_width - cur_rate / 2
			+ $urandom_range(0, 31);
		if ($urandom_range(0, 9) == 0) center = {$urandom, $urandom};
		lvl = $urandom;
		if ($urandom_range(0, 1)) lvl = 16'($signed($urandom_range(0, 20000)) - 10000);
		issue(CMD_FOLD, center, $urandom_range(0, cur_fft == 0 ? 1023 : cur_fft), lvl, 0);
	endtask

	task automatic random_item();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 80) random_fold();
		else if (pick < 92) issue(CMD_READ, 0, 0, 0, $urandom_range(0, 63));
		else if (pick < 96) issue(CMD_READ, 0, 0, 0, $urandom);
		else if (pick < 98) issue(CMD_COUNT, 0, 0, 0, 0);
		else issue(CMD_CLEAR, 0, 0, 0, 0);
	endtask

	initial begin
		burst_left = 0;
		sent_items = 0;
		cur_start = 0;
		cur_width = 1;
		cur_rate = 1;
		cur_fft = 1024;
		repeat (11) @(negedge clk);
		arst_n <= 1;

		issue(CMD_COUNT, 0, 0, 0, 0);
		issue(CMD_FOLD, 0, 512, 16'h7fff, 0);
		issue(CMD_READ, 0, 0, 0, 12'hfff);
		set_plan(1000, 10, 640, 320, 10, 32, 64);
		issue(CMD_FOLD, 1000, 33, 16'h7fff, 0);
		issue(CMD_FOLD, 1000, 34, 16'h8000, 0);
		issue(CMD_FOLD, 1000, 40, 16'h0080, 0);
		issue(CMD_FOLD, 1000, 40, 16'hff80, 0);
		issue(CMD_FOLD, 1000, 40, 16'h7f00, 0);
		issue(CMD_FOLD, 1000, 63, 16'h0100, 0);
		issue(CMD_FOLD, 1000, 10, 16'h0100, 0);
		issue(CMD_FOLD, 1000, 100, 16'h0100, 0);
		issue(CMD_FOLD, 900, 40, 16'h0100, 0);
		issue(CMD_READ, 0, 0, 0, 2);
		issue(CMD_COUNT, 0, 0, 0, 0);
		issue(CMD_CLEAR, 0, 0, 0, 0);
		issue(CMD_COUNT, 0, 0, 0, 0);
		set_plan(0, 0, 1000, 500, 0, 16, 16);
		issue(CMD_FOLD, 0, 9, 16'h0200, 0);
		set_plan(0, 1, 7, 100, 0, 16, 0);
		issue(CMD_FOLD, 3, 0, 16'h0200, 0);
		set_plan(64'hf_ffff_fff0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 4096, 1024);
		issue(CMD_FOLD, 64'hf_ffff_fff0, 1023, 16'h1234, 0);
		issue(CMD_COUNT, 0, 0, 0, 0);

		set_plan(5000, 100, 3200, 1600, 50, 40, 32);
		repeat (300) random_item();
		set_plan(0, 1, 16, 8, 1, 4096, 16);
		repeat (150) random_item();
		set_plan(7, 3, 200, 100, 0, 8191, 8);
		repeat (150) random_item();
		set_plan(123456, 25, 1000, 64, 0, 20, 128);
		repeat (150) random_item();

		drain_block();
		$display("Sent %0d transactions under the reset plan and eight written plans;",
			sent_items);
		$display("%0d folds landed in the store.", seen_hits);
		if (errors == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

	initial begin
		#100ms;
		$display("== FAIL ==");
		$finish;
	end
endmodule

// File: sim.f
rtl/sspb_pkg.sv
rtl/sspb_div.sv
rtl/sspb_front.sv
rtl/sspb_back.sv
rtl/spectrum_sweep_peak_hold_binner.sv
sim/sspb_checker.sv
sim/testbench.sv
